### hdl/round_robin_thread_scheduler_core_assert.svh
// Assertion macros for the thread scheduler core
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, quiet during reset
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RRTS_ASSERT_IMP(lbl, ante, cons, msg)
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

	localparam int THREAD_SLOTS = 8;
	localparam int SLOT_W       = $clog2(THREAD_SLOTS);

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		SLOT_FINISHED = 2'd0,
		SLOT_READY    = 2'd1,
		SLOT_RUNNING  = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_CREATE = 2'd1,
		REQ_EXIT   = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_FREE  = 2'd1,
		STATUS_BAD_SLOT = 2'd2,
		STATUS_NO_READY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_DEMOTE,
		SEQ_SCAN,
		SEQ_CREATE,
		SEQ_QUERY
	} seq_t;

	// Write port of the slot table
	typedef struct packed {
		logic      en;
		slot_idx_t addr;
		slot_st_t  data;
	} slot_wr_t;

	// Next slot in round-robin order
	function automatic slot_idx_t slot_next(slot_idx_t s);
		if (s == slot_idx_t'(THREAD_SLOTS - 1)) begin
			return '0;
		end
		return s + slot_idx_t'(1);
	endfunction

	// Low three bits of a slot number for the result fields
	function automatic logic [2:0] slot_out(slot_idx_t s);
		logic [SLOT_W+2:0] w;
		w = {3'b000, s};
		return w[2:0];
	endfunction

endpackage

### hdl/rrts_req_if.sv
`timescale 1ns / 1ps

interface rrts_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [3:0] target_thread;

	modport source (output valid, output req_type, output target_thread, input ready);
	modport sink (input valid, input req_type, input target_thread, output ready);
endinterface

### hdl/rrts_rsp_if.sv
`timescale 1ns / 1ps

interface rrts_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] current_thread;
	logic [2:0] previous_thread;
	logic       switched;
	logic [2:0] new_thread;
	logic       target_finished;

	modport source (
		output valid, output status, output current_thread, output previous_thread,
		output switched, output new_thread, output target_finished, input ready
	);
	modport sink (
		input valid, input status, input current_thread, input previous_thread,
		input switched, input new_thread, input target_finished, output ready
	);
endinterface

### hdl/rrts_slot_table.sv
`timescale 1ns / 1ps

module rrts_slot_table (
	input  logic              clk,
	input  logic              arst_n,
	input  rrts_pkg::slot_wr_t  wr,
	input  rrts_pkg::slot_idx_t rd_addr,
	output rrts_pkg::slot_st_t  rd_data
);
	import rrts_pkg::*;

	slot_st_t slot_q [THREAD_SLOTS];

	// Reset to slot 0 running, the rest finished; take one write a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				slot_q[i] <= (i == 0) ? SLOT_RUNNING : SLOT_FINISHED;
			end
		end else if (wr.en) begin
			slot_q[wr.addr] <= wr.data;
		end
	end

	// Single read port
	assign rd_data = slot_q[rd_addr];

endmodule

### hdl/round_robin_thread_scheduler_core.sv
`timescale 1ns / 1ps
`include "round_robin_thread_scheduler_core_assert.svh"

// Round-robin thread scheduler. One request item in, one result item out.
// A small sequencer walks the slot table through a single read/write port,
// one slot per cycle. A query reads the target slot; a create examines
// slots from slot 1 upward; a tick or exit first demotes or finishes the
// current slot, then visits slots from the current slot plus one round to
// the current slot itself. One request is in flight at a time: a new
// item is taken once the previous result has been taken or is taken in
// the same cycle.
module round_robin_thread_scheduler_core (
	input  logic clk,
	input  logic arst_n,
	rrts_req_if.sink   req,
	rrts_rsp_if.source rsp
);
	import rrts_pkg::*;

	seq_t      state_q, state_d;
	slot_idx_t running_q;
	slot_idx_t scan_q;
	req_t      req_q;
	logic [3:0] target_q;

	slot_wr_t  tbl_wr;
	slot_idx_t rd_addr;
	slot_st_t  rd_data;

	logic      accept;
	logic      hit;
	logic      scan_last;
	logic      finish;
	logic      tgt_bad;
	logic [SLOT_W+3:0] tgt_ext;
	slot_idx_t tgt_idx;

	status_t    res_status;
	logic [2:0] res_cur;
	logic       res_switched;
	logic [2:0] res_new;
	logic       res_fin;

	logic       out_valid_q;
	status_t    out_status_q;
	logic [2:0] out_cur_q;
	logic [2:0] out_prev_q;
	logic       out_switched_q;
	logic [2:0] out_new_q;
	logic       out_fin_q;

	rrts_slot_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Accept a request when idle and the result register is free
	assign req.ready = (state_q == SEQ_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Query target range check and table index
	assign tgt_ext = {{SLOT_W{1'b0}}, target_q};
	assign tgt_idx = tgt_ext[SLOT_W-1:0];
	assign tgt_bad = int'(target_q) >= THREAD_SLOTS;

	// Select the table read address
	always_comb begin
		case (state_q)
			SEQ_DEMOTE: rd_addr = running_q;
			SEQ_QUERY:  rd_addr = tgt_idx;
			default:    rd_addr = scan_q;
		endcase
	end

	// Scan compare and end of scan
	always_comb begin
		hit       = 1'b0;
		scan_last = 1'b0;
		case (state_q)
			SEQ_SCAN: begin
				hit       = (rd_data == SLOT_READY);
				scan_last = (scan_q == running_q);
			end
			SEQ_CREATE: begin
				hit       = (rd_data == SLOT_FINISHED);
				scan_last = (scan_q == slot_idx_t'(THREAD_SLOTS - 1));
			end
			default: begin
				hit       = 1'b0;
				scan_last = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					case (req_t'(req.req_type))
						REQ_CREATE: state_d = SEQ_CREATE;
						REQ_QUERY:  state_d = SEQ_QUERY;
						default:    state_d = SEQ_DEMOTE;
					endcase
				end
			end
			SEQ_DEMOTE: state_d = SEQ_SCAN;
			SEQ_SCAN, SEQ_CREATE: begin
				if (hit || scan_last) begin
					state_d = SEQ_IDLE;
				end
			end
			SEQ_QUERY: state_d = SEQ_IDLE;
			default:   state_d = SEQ_IDLE;
		endcase
	end

	assign finish = (state_q != SEQ_IDLE) && (state_d == SEQ_IDLE);

	// Table writes and result fields
	always_comb begin
		tbl_wr       = '{en: 1'b0, addr: running_q, data: SLOT_FINISHED};
		res_status   = STATUS_OK;
		res_cur      = slot_out(running_q);
		res_switched = 1'b0;
		res_new      = 3'b000;
		res_fin      = 1'b0;
		case (state_q)
			SEQ_DEMOTE: begin
				if (req_q == REQ_EXIT) begin
					tbl_wr.en = 1'b1;
				end else if (rd_data == SLOT_RUNNING) begin
					tbl_wr.en   = 1'b1;
					tbl_wr.data = SLOT_READY;
				end
			end
			SEQ_SCAN: begin
				if (hit) begin
					tbl_wr       = '{en: 1'b1, addr: scan_q, data: SLOT_RUNNING};
					res_cur      = slot_out(scan_q);
					res_switched = (scan_q != running_q);
				end else begin
					res_status = STATUS_NO_READY;
				end
			end
			SEQ_CREATE: begin
				if (hit) begin
					tbl_wr  = '{en: 1'b1, addr: scan_q, data: SLOT_READY};
					res_new = slot_out(scan_q);
				end else begin
					res_status = STATUS_NO_FREE;
				end
			end
			SEQ_QUERY: begin
				if (tgt_bad) begin
					res_status = STATUS_BAD_SLOT;
				end else begin
					res_fin = (rd_data == SLOT_FINISHED);
				end
			end
			default: begin
				tbl_wr.en = 1'b0;
			end
		endcase
	end

	// Sequencer, running slot and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			running_q <= '0;
			scan_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (req_t'(req.req_type) == REQ_CREATE) begin
					scan_q <= slot_idx_t'(1);
				end else begin
					scan_q <= slot_next(running_q);
				end
			end else if (state_q == SEQ_SCAN || state_q == SEQ_CREATE) begin
				scan_q <= slot_next(scan_q);
			end
			if (state_q == SEQ_SCAN && hit) begin
				running_q <= scan_q;
			end
		end
	end

	// Hold the request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_t'(req.req_type);
			target_q <= req.target_thread;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result item
	always_ff @(posedge clk) begin
		if (finish) begin
			out_status_q   <= res_status;
			out_cur_q      <= res_cur;
			out_prev_q     <= slot_out(running_q);
			out_switched_q <= res_switched;
			out_new_q      <= res_new;
			out_fin_q      <= res_fin;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.current_thread  = out_cur_q;
	assign rsp.previous_thread = out_prev_q;
	assign rsp.switched        = out_switched_q;
	assign rsp.new_thread      = out_new_q;
	assign rsp.target_finished = out_fin_q;

	// Checks
	`RRTS_ASSERT_NXT(a_busy_after_accept, accept, (state_q != SEQ_IDLE) && !out_valid_q, "request accepted but sequencer idle or result pending")
	`RRTS_ASSERT_IMP(a_result_from_work, $rose(out_valid_q), $past(state_q) != SEQ_IDLE, "result raised without a request in progress")
	`RRTS_ASSERT_IMP(a_switch_ok, out_valid_q && out_switched_q, (out_status_q == STATUS_OK) && (out_cur_q != out_prev_q), "switch reported with bad status or same slot")

endmodule

### verif/sched_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the thread scheduler, keeps its
// own copy of the slot table and compares every result item with the answer
// predicted for the oldest outstanding request.
module sched_checker (
	input  logic clk,
	input  logic arst_n,
	rrts_req_if  req,
	rrts_rsp_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   switch_count,
	output int   no_ready_count,
	output int   no_free_count,
	output int   bad_slot_count
);
	import rrts_pkg::*;

	localparam int REPORT_CAP = 60;

	typedef struct {
		status_t    status;
		logic [2:0] current_thread;
		logic [2:0] previous_thread;
		logic       switched;
		logic [2:0] new_thread;
		logic       target_finished;
	} sched_answer_t;

	slot_st_t      slot_table [THREAD_SLOTS];
	slot_idx_t     running;
	sched_answer_t answers [$];
	int            fails;
	int            switches;
	int            no_ready;
	int            no_free;
	int            bad_slot;

	// Demote the running slot, then scan round-robin with the current slot last
	function automatic bit resume_next();
		slot_idx_t idx;
		if (slot_table[running] == SLOT_RUNNING) begin
			slot_table[running] = SLOT_READY;
		end
		for (int k = 1; k <= THREAD_SLOTS; k++) begin
			idx = slot_idx_t'((int'(running) + k) % THREAD_SLOTS);
			if (slot_table[idx] == SLOT_READY) begin
				running = idx;
				slot_table[idx] = SLOT_RUNNING;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Advance the slot table by one request and work out its result item
	function automatic sched_answer_t serve_request(req_t kind, logic [3:0] target);
		sched_answer_t a;
		slot_idx_t     from;
		from              = running;
		a.status          = STATUS_OK;
		a.new_thread      = '0;
		a.target_finished = 1'b0;
		case (kind)
			REQ_TICK: begin
				if (!resume_next()) begin
					a.status = STATUS_NO_READY;
				end
			end
			REQ_CREATE: begin
				a.status = STATUS_NO_FREE;
				for (int i = 1; i < THREAD_SLOTS; i++) begin
					if (a.status == STATUS_NO_FREE && slot_table[i] == SLOT_FINISHED) begin
						slot_table[i] = SLOT_READY;
						a.new_thread  = 3'(i);
						a.status      = STATUS_OK;
					end
				end
			end
			REQ_EXIT: begin
				slot_table[running] = SLOT_FINISHED;
				if (!resume_next()) begin
					a.status = STATUS_NO_READY;
				end
			end
			default: begin
				if (int'(target) >= THREAD_SLOTS) begin
					a.status = STATUS_BAD_SLOT;
				end else begin
					a.target_finished = (slot_table[slot_idx_t'(target)] == SLOT_FINISHED);
				end
			end
		endcase
		a.current_thread  = 3'(running);
		a.previous_thread = 3'(from);
		a.switched        = (running != from);
		return a;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= REPORT_CAP) begin
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		end
	endfunction

	// Take results before requests: a result never belongs to a request of the same edge
	always @(posedge clk) begin
		sched_answer_t want;
		if (!arst_n) begin
			foreach (slot_table[i]) begin
				slot_table[i] = SLOT_FINISHED;
			end
			slot_table[0] = SLOT_RUNNING;
			running       = '0;
			answers.delete();
			fails    = 0;
			switches = 0;
			no_ready = 0;
			no_free  = 0;
			bad_slot = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers.size() == 0) begin
					fails++;
					if (fails <= REPORT_CAP) begin
						$error("result item with no request outstanding");
					end
				end else begin
					want = answers.pop_front();
					check_field("status", 8'(want.status), 8'(rsp.status));
					check_field("current_thread", 8'(want.current_thread),
						8'(rsp.current_thread));
					check_field("previous_thread", 8'(want.previous_thread),
						8'(rsp.previous_thread));
					check_field("switched", 8'(want.switched), 8'(rsp.switched));
					check_field("new_thread", 8'(want.new_thread), 8'(rsp.new_thread));
					check_field("target_finished", 8'(want.target_finished),
						8'(rsp.target_finished));
					switches += int'(want.switched);
					no_ready += int'(want.status == STATUS_NO_READY);
					no_free  += int'(want.status == STATUS_NO_FREE);
					bad_slot += int'(want.status == STATUS_BAD_SLOT);
				end
			end
			if (req.valid && req.ready) begin
				answers.push_back(serve_request(req_t'(req.req_type), req.target_thread));
			end
		end
		pending        <= answers.size();
		fail_count     <= fails;
		switch_count   <= switches;
		no_ready_count <= no_ready;
		no_free_count  <= no_free;
		bad_slot_count <= bad_slot;
	end

endmodule

### verif/tb_round_robin_thread_scheduler_core.sv
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler_core;
	import rrts_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 1100;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   switch_count;
	int   no_ready_count;
	int   no_free_count;
	int   bad_slot_count;
	int   sent_by_kind [4];
	int   burst_left;
	int   cycles = 0;

	rrts_req_if req_ch ();
	rrts_rsp_if rsp_ch ();

	round_robin_thread_scheduler_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sched_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.fail_count     (fail_count),
		.pending        (pending),
		.switch_count   (switch_count),
		.no_ready_count (no_ready_count),
		.no_free_count  (no_free_count),
		.bad_slot_count (bad_slot_count)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_round_robin_thread_scheduler_core: done, errors");
			$finish;
		end
	end

	// Stall the result channel, switching pattern every so often
	initial begin
		int mode;
		int span;
		int beat;
		rsp_ch.ready = 1'b0;
		beat = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(posedge clk);
				beat++;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= (beat % 3 != 0);
				endcase
			end
		end
	end

	// Offer one item and hold it until taken; open a new burst, sometimes after a gap
	task automatic send_request(req_t kind, logic [3:0] target);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.target_thread <= target;
		sent_by_kind[kind]++;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Hold off until every result item has come back
	task automatic drain_all();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [3:0] any_target();
		return 4'($urandom_range(0, 15));
	endfunction

	// Run a stretch of requests biased to fill, empty or churn the slot table
	task automatic random_phase(int count);
		int         bias;
		int         roll;
		req_t       kind;
		logic [3:0] target;
		bias = $urandom_range(0, 2);
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (bias == 0) begin
				kind = (roll < 45) ? REQ_CREATE : (roll < 75) ? REQ_TICK :
					(roll < 90) ? REQ_QUERY : REQ_EXIT;
			end else if (bias == 1) begin
				kind = (roll < 40) ? REQ_EXIT : (roll < 70) ? REQ_TICK :
					(roll < 85) ? REQ_QUERY : REQ_CREATE;
			end else begin
				kind = req_t'(roll % 4);
			end
			if ($urandom_range(0, 5) == 0) begin
				target = 4'($urandom_range(THREAD_SLOTS, 15));
			end else begin
				target = 4'($urandom_range(0, THREAD_SLOTS - 1));
			end
			send_request(kind, target);
		end
	endtask

	initial begin
		int done_items;
		int chunk;
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = REQ_TICK;
		req_ch.target_thread = '0;
		burst_left           = 0;
		foreach (sent_by_kind[i]) begin
			sent_by_kind[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries at the table edges and past it
		send_request(REQ_QUERY, 4'd0);
		send_request(REQ_QUERY, 4'd15);
		send_request(REQ_QUERY, 4'd8);
		// Tick alone: slot 0 stays running
		send_request(REQ_TICK, any_target());
		send_request(REQ_CREATE, any_target());
		send_request(REQ_TICK, any_target());
		send_request(REQ_TICK, any_target());
		// Exit slot 0, then exit with nothing left ready, then exit a finished slot
		send_request(REQ_EXIT, any_target());
		send_request(REQ_EXIT, any_target());
		send_request(REQ_EXIT, any_target());
		send_request(REQ_TICK, any_target());
		send_request(REQ_QUERY, 4'd1);
		// Create reuses the idle current slot; tick picks it up last
		send_request(REQ_CREATE, any_target());
		send_request(REQ_TICK, any_target());
		// Fill the table and overflow it
		repeat (7) send_request(REQ_CREATE, any_target());
		send_request(REQ_QUERY, 4'd7);
		send_request(REQ_TICK, any_target());
		send_request(REQ_QUERY, 4'd10);
		drain_all();

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			chunk = $urandom_range(40, 120);
			random_phase(chunk);
			done_items += chunk;
			if ($urandom_range(0, 3) == 0) begin
				drain_all();
			end
		end
		drain_all();
		repeat (THREAD_SLOTS + 8) @(posedge clk);

		$display("sent %0d ticks, %0d creates, %0d exits, %0d queries",
			sent_by_kind[REQ_TICK], sent_by_kind[REQ_CREATE],
			sent_by_kind[REQ_EXIT], sent_by_kind[REQ_QUERY]);
		$display("saw %0d switches, %0d nothing ready, %0d table full, %0d bad slot numbers",
			switch_count, no_ready_count, no_free_count, bad_slot_count);
		if (fail_count == 0) begin
			$display("tb_round_robin_thread_scheduler_core: done, clean");
		end else begin
			$display("tb_round_robin_thread_scheduler_core: done, errors");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/rrts_pkg.sv
hdl/rrts_req_if.sv
hdl/rrts_rsp_if.sv
hdl/rrts_slot_table.sv
hdl/round_robin_thread_scheduler_core.sv
verif/sched_checker.sv
verif/tb_round_robin_thread_scheduler_core.sv
